// ===== rtl/core/msfd_pkg.sv =====
// Shared types and constants for the magic-word sync frame deframer.
// Used by msfd_front, msfd_fifo, msfd_back and magic_sync_frame_deframer.
`default_nettype none
package msfd_pkg;

    typedef enum logic [1:0] {
        PH_SCAN    = 2'd0,
        PH_SWALLOW = 2'd1,
        PH_HEADER  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    localparam logic [1:0]  KIND_FWD     = 2'd0;
    localparam logic [1:0]  KIND_DROP    = 2'd1;
    localparam logic [1:0]  KIND_PAYLOAD = 2'd2;

    localparam logic [31:0] MAGIC_FRAME  = 32'h5653_544A;
    localparam logic [31:0] MAGIC_STATE  = 32'h5653_5453;

    localparam logic [2:0]  HDR_STATE    = 3'd0;
    localparam logic [2:0]  HDR_CLASS    = 3'd1;
    localparam logic [2:0]  HDR_CONF     = 3'd2;
    localparam logic [2:0]  HDR_LEN0     = 3'd3;
    localparam logic [2:0]  HDR_LEN1     = 3'd4;
    localparam logic [2:0]  HDR_LEN2     = 3'd5;
    localparam logic [2:0]  HDR_LEN3     = 3'd6;

    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd500;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  hdr_state;
        logic [7:0]  class_index;
        logic [7:0]  confidence;
        logic [31:0] frame_length;
        logic [31:0] frame_number;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic valid;
        logic full;
    } fifo_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/msfd_front.sv =====
// Front end: accepts bytes, tracks sync, header and payload, emits result records.
// Depends on msfd_pkg.
`default_nettype none
module msfd_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          rx_byte,
    input  wire logic [31:0]         now_ms,
    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data,
    output msfd_pkg::rec_t           rec,
    output logic                     push
);

    msfd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] window_reg, window_next;
    logic [2:0]  hdr_pos_reg, hdr_pos_next;
    logic [7:0]  state_reg, state_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  conf_reg, conf_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] remaining_reg, remaining_next;
    logic        fwd_reg, fwd_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [31:0] count_reg, count_next;
    logic [15:0] min_interval_reg;
    logic [31:0] elapsed;

    assign elapsed = now_ms - last_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= msfd_pkg::MIN_INTERVAL_RESET;
        end
        else if (cfg_wr_en)
        begin
            min_interval_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= msfd_pkg::PH_SCAN;
            window_reg    <= '0;
            hdr_pos_reg   <= '0;
            state_reg     <= '0;
            class_reg     <= '0;
            conf_reg      <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
            fwd_reg       <= 1'b0;
            last_time_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            window_reg    <= window_next;
            hdr_pos_reg   <= hdr_pos_next;
            state_reg     <= state_next;
            class_reg     <= class_next;
            conf_reg      <= conf_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            fwd_reg       <= fwd_next;
            last_time_reg <= last_time_next;
            count_reg     <= count_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        window_next    = window_reg;
        hdr_pos_next   = hdr_pos_reg;
        state_next     = state_reg;
        class_next     = class_reg;
        conf_next      = conf_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        fwd_next       = fwd_reg;
        last_time_next = last_time_reg;
        count_next     = count_reg;
        push           = 1'b0;
        rec            = '0;

        if (accept)
        begin
            unique case (phase_reg)
                msfd_pkg::PH_SWALLOW:
                begin
                    phase_next = msfd_pkg::PH_SCAN;
                end
                msfd_pkg::PH_HEADER:
                begin
                    case (hdr_pos_reg)
                        msfd_pkg::HDR_STATE: state_next = rx_byte;
                        msfd_pkg::HDR_CLASS: class_next = rx_byte;
                        msfd_pkg::HDR_CONF:  conf_next  = rx_byte;
                        msfd_pkg::HDR_LEN0:  length_next[7:0]   = rx_byte;
                        msfd_pkg::HDR_LEN1:  length_next[15:8]  = rx_byte;
                        msfd_pkg::HDR_LEN2:  length_next[23:16] = rx_byte;
                        msfd_pkg::HDR_LEN3:  length_next[31:24] = rx_byte;
                        default: ;
                    endcase
                    if (hdr_pos_reg == msfd_pkg::HDR_LEN3)
                    begin
                        hdr_pos_next   = '0;
                        remaining_next = length_next;
                        phase_next     = (length_next == '0) ? msfd_pkg::PH_SCAN
                                                             : msfd_pkg::PH_PAYLOAD;
                        push           = 1'b1;
                        rec.hdr_state    = state_reg;
                        rec.class_index  = class_reg;
                        rec.confidence   = conf_reg;
                        rec.frame_length = length_next;
                        if (elapsed < {16'd0, min_interval_reg})
                        begin
                            fwd_next         = 1'b0;
                            rec.kind         = msfd_pkg::KIND_DROP;
                            rec.frame_number = count_reg;
                        end
                        else
                        begin
                            fwd_next         = 1'b1;
                            last_time_next   = now_ms;
                            count_next       = count_reg + 32'd1;
                            rec.kind         = msfd_pkg::KIND_FWD;
                            rec.frame_number = count_next;
                            rec.last         = (length_next == '0);
                        end
                    end
                    else
                    begin
                        hdr_pos_next = hdr_pos_reg + 3'd1;
                    end
                end
                msfd_pkg::PH_PAYLOAD:
                begin
                    remaining_next = remaining_reg - 32'd1;
                    if (remaining_reg == 32'd1)
                    begin
                        phase_next = msfd_pkg::PH_SCAN;
                    end
                    push             = fwd_reg;
                    rec.kind         = msfd_pkg::KIND_PAYLOAD;
                    rec.data_byte    = rx_byte;
                    rec.hdr_state    = state_reg;
                    rec.class_index  = class_reg;
                    rec.confidence   = conf_reg;
                    rec.frame_length = length_reg;
                    rec.frame_number = count_reg;
                    rec.last         = (remaining_reg == 32'd1);
                end
                default:
                begin
                    window_next = {window_reg[23:0], rx_byte};
                    if (window_next == msfd_pkg::MAGIC_STATE)
                    begin
                        phase_next = msfd_pkg::PH_SWALLOW;
                    end
                    else if (window_next == msfd_pkg::MAGIC_FRAME)
                    begin
                        phase_next   = msfd_pkg::PH_HEADER;
                        hdr_pos_next = '0;
                        length_next  = '0;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/msfd_fifo.sv =====
// Short result queue between front end and output stage.
// Depends on msfd_pkg.
`default_nettype none
module msfd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire msfd_pkg::rec_t      wr_rec,
    input  wire logic                pop,
    output msfd_pkg::rec_t           rd_rec,
    output msfd_pkg::fifo_stat_t     stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    msfd_pkg::rec_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign stat.valid = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign rd_rec     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/msfd_back.sv =====
// Output stage: pops records from the queue into the result register and packs them.
// Depends on msfd_pkg.
`default_nettype none
module msfd_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire msfd_pkg::rec_t      rd_rec,
    input  wire msfd_pkg::fifo_stat_t stat,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [95:0]              m_tdata,
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);

    logic           valid_reg;
    msfd_pkg::rec_t out_reg;

    assign pop = stat.valid && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_tready)
        begin
            valid_reg <= stat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= rd_rec;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {out_reg.frame_number, out_reg.frame_length, out_reg.confidence,
                       out_reg.class_index, out_reg.hdr_state, out_reg.data_byte};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule
`default_nettype wire

// ===== rtl/core/magic_sync_frame_deframer.sv =====
// Top level of the magic-word sync frame deframer: front end, result queue, output stage.
// Depends on msfd_pkg, msfd_front, msfd_fifo and msfd_back.
//
// channel   dir  tdata                                       tuser  tlast
// s_axis    in   [7:0] rx_byte, [39:8] now_ms                -      -
// m_axis    out  [7:0] data_byte, [15:8] hdr_state,          kind   last
//                [23:16] class_index, [31:24] confidence,
//                [63:32] frame_length, [95:64] frame_number
// cfg       in   cfg_wr_data = min_interval_ms, written when cfg_wr_en is high
//
// One byte is taken per cycle while s_tready is high; each byte updates the front end
// state in that cycle. A result is written to the queue at the edge that takes its byte
// and moves into the output register, which drives m_tvalid, once it is empty or read out.
// s_tready falls only when the FIFO_DEPTH-entry result queue is full.
// Reset clears control state but not stored records, and sets min_interval_ms to 500.
`default_nettype none
module magic_sync_frame_deframer
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // [7:0] rx_byte, [39:8] now_ms
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // data_byte, hdr_state, class_index,
                                         // confidence, frame_length, frame_number
    output logic [1:0]        m_tuser,   // [1:0] kind
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data
);

    msfd_pkg::rec_t       front_rec;
    msfd_pkg::rec_t       queue_rec;
    msfd_pkg::fifo_stat_t queue_stat;
    logic                 push;
    logic                 pop;
    logic                 accept;

    assign s_tready = !queue_stat.full;
    assign accept   = s_tvalid && s_tready;

    msfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (s_tdata[7:0]),
        .now_ms      (s_tdata[39:8]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rec         (front_rec),
        .push        (push)
    );

    msfd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (front_rec),
        .pop    (pop),
        .rd_rec (queue_rec),
        .stat   (queue_stat)
    );

    msfd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_rec   (queue_rec),
        .stat     (queue_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !queue_stat.full)
        else $error("result pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> queue_stat.valid)
        else $error("result popped from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser == msfd_pkg::KIND_PAYLOAD ||
                                 m_tuser == msfd_pkg::KIND_FWD))
        else $error("last flag on dropped header");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != msfd_pkg::KIND_PAYLOAD |-> m_tdata[7:0] == 8'd0)
        else $error("header result carries nonzero data byte");

endmodule
`default_nettype wire

// ===== tb/deframe_checker.sv =====
`timescale 1ns / 1ps
// Checker for magic_sync_frame_deframer: watches the byte, result and interval channels,
// runs its own deframer on every accepted byte and compares each result transfer in order.
// Depends on msfd_pkg for the result record and the phase, kind and header codes.
module deframe_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          errors,
    output int          pending,
    output int          forwarded_seen,
    output int          dropped_seen,
    output int          payload_seen
);

    logic [15:0]      min_gap_ms;
    logic [31:0]      window;
    logic [2:0]       window_fill;
    msfd_pkg::phase_t phase;
    logic [2:0]       hdr_pos;
    logic [7:0]       held_state;
    logic [7:0]       held_class;
    logic [7:0]       held_conf;
    logic [31:0]      held_length;
    logic [31:0]      bytes_left;
    logic             forwarding;
    logic [31:0]      last_fwd_ms;
    logic [31:0]      fwd_count;
    msfd_pkg::rec_t   awaited_records[$];

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task queue_record(input logic [1:0] kind, input logic [7:0] data, input logic last);
        msfd_pkg::rec_t r;
        r.kind         = kind;
        r.data_byte    = data;
        r.hdr_state    = held_state;
        r.class_index  = held_class;
        r.confidence   = held_conf;
        r.frame_length = held_length;
        r.frame_number = fwd_count;
        r.last         = last;
        awaited_records.push_back(r);
    endtask

    task deframe_byte(input logic [7:0] b, input logic [31:0] now);
        logic [31:0] elapsed;
        case (phase)
            msfd_pkg::PH_SWALLOW:
                phase = msfd_pkg::PH_SCAN;
            msfd_pkg::PH_HEADER:
            begin
                case (hdr_pos)
                    msfd_pkg::HDR_STATE: held_state = b;
                    msfd_pkg::HDR_CLASS: held_class = b;
                    msfd_pkg::HDR_CONF:  held_conf = b;
                    default:   held_length[8 * (hdr_pos - msfd_pkg::HDR_LEN0) +: 8] = b;
                endcase
                if (hdr_pos != msfd_pkg::HDR_LEN3)
                    hdr_pos = hdr_pos + 3'd1;
                else
                begin
                    hdr_pos = msfd_pkg::HDR_STATE;
                    bytes_left = held_length;
                    phase = (held_length == 32'd0) ? msfd_pkg::PH_SCAN : msfd_pkg::PH_PAYLOAD;
                    elapsed = now - last_fwd_ms;
                    if (elapsed < {16'd0, min_gap_ms})
                    begin
                        forwarding = 1'b0;
                        queue_record(msfd_pkg::KIND_DROP, 8'd0, 1'b0);
                    end
                    else
                    begin
                        forwarding = 1'b1;
                        last_fwd_ms = now;
                        fwd_count = fwd_count + 32'd1;
                        queue_record(msfd_pkg::KIND_FWD, 8'd0, held_length == 32'd0);
                    end
                end
            end
            msfd_pkg::PH_PAYLOAD:
            begin
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                    phase = msfd_pkg::PH_SCAN;
                if (forwarding)
                    queue_record(msfd_pkg::KIND_PAYLOAD, b, bytes_left == 32'd0);
            end
            default:
            begin
                window = {window[23:0], b};
                if (window_fill < 3'd4)
                    window_fill = window_fill + 3'd1;
                if (window_fill == 3'd4)
                begin
                    if (window == msfd_pkg::MAGIC_STATE)
                        phase = msfd_pkg::PH_SWALLOW;
                    else if (window == msfd_pkg::MAGIC_FRAME)
                    begin
                        phase = msfd_pkg::PH_HEADER;
                        hdr_pos = msfd_pkg::HDR_STATE;
                        held_length = 32'd0;
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        msfd_pkg::rec_t want;
        if (!rst_n)
        begin
            min_gap_ms  = msfd_pkg::MIN_INTERVAL_RESET;
            window      = 32'd0;
            window_fill = 3'd0;
            phase       = msfd_pkg::PH_SCAN;
            hdr_pos     = msfd_pkg::HDR_STATE;
            held_state  = 8'd0;
            held_class  = 8'd0;
            held_conf   = 8'd0;
            held_length = 32'd0;
            bytes_left  = 32'd0;
            forwarding  = 1'b0;
            last_fwd_ms = 32'd0;
            fwd_count   = 32'd0;
            awaited_records.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_records.size() == 0)
                    report_mismatch("result with none expected", m_tdata[31:0], 32'd0);
                else
                begin
                    want = awaited_records.pop_front();
                    if (m_tuser != want.kind)
                        report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                    if (m_tdata[7:0] != want.data_byte)
                        report_mismatch("data_byte", 32'(m_tdata[7:0]), 32'(want.data_byte));
                    if (m_tdata[15:8] != want.hdr_state)
                        report_mismatch("hdr_state", 32'(m_tdata[15:8]), 32'(want.hdr_state));
                    if (m_tdata[23:16] != want.class_index)
                        report_mismatch("class_index", 32'(m_tdata[23:16]),
                                        32'(want.class_index));
                    if (m_tdata[31:24] != want.confidence)
                        report_mismatch("confidence", 32'(m_tdata[31:24]),
                                        32'(want.confidence));
                    if (m_tdata[63:32] != want.frame_length)
                        report_mismatch("frame_length", m_tdata[63:32], want.frame_length);
                    if (m_tdata[95:64] != want.frame_number)
                        report_mismatch("frame_number", m_tdata[95:64], want.frame_number);
                    if (m_tlast != want.last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
                case (m_tuser)
                    msfd_pkg::KIND_FWD:     forwarded_seen++;
                    msfd_pkg::KIND_DROP:    dropped_seen++;
                    msfd_pkg::KIND_PAYLOAD: payload_seen++;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata[7:0], s_tdata[39:8]);
            if (cfg_wr_en)
                min_gap_ms = cfg_wr_data;
            pending <= awaited_records.size();
        end
    end

endmodule

// ===== tb/magic_sync_frame_deframer_test.sv =====
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, framed byte stimulus with idle gaps,
// result-side stalls and interval register writes; verdict from deframe_checker's count.
// Depends on msfd_pkg, magic_sync_frame_deframer and deframe_checker.
module magic_sync_frame_deframer_test;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_OFF_CYCLES = 150;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    int          errors;
    int          pending;
    int          forwarded_seen;
    int          dropped_seen;
    int          payload_seen;

    bit          idling;
    bit          hold_off_request;
    logic [31:0] clock_ms;
    int unsigned ms_step_max;
    int          bytes_sent;
    int          settings_used;

    magic_sync_frame_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    deframe_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .errors         (errors),
        .pending        (pending),
        .forwarded_seen (forwarded_seen),
        .dropped_seen   (dropped_seen),
        .payload_seen   (payload_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idling && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {clock_ms, b};
        clock_ms = clock_ms + $urandom_range(0, ms_step_max);
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_magic(input logic [31:0] word);
        for (int i = 3; i >= 0; i--)
            send_byte(word[8 * i +: 8]);
    endtask

    // Sync letters or random bytes but no frame terminator, so noise never starts a frame.
    task automatic send_noise(input int count);
        logic [7:0] b;
        repeat (count)
        begin
            if ($urandom_range(0, 1) == 0)
                b = msfd_pkg::MAGIC_FRAME[8 * $urandom_range(1, 3) +: 8];
            else
            begin
                b = 8'($urandom);
                if (b == msfd_pkg::MAGIC_FRAME[7:0])
                    b = b ^ 8'h80;
            end
            send_byte(b);
        end
        // flush a pending swallow so the next sync word is scanned whole
        send_byte(8'h00);
    endtask

    task automatic send_frame(input logic [7:0] st, input logic [7:0] cls, input logic [7:0] conf,
                              input logic [31:0] len, input int unsigned count);
        int unsigned i;
        send_magic(msfd_pkg::MAGIC_FRAME);
        send_byte(st);
        send_byte(cls);
        send_byte(conf);
        for (int k = 0; k < 4; k++)
            send_byte(len[8 * k +: 8]);
        i = 0;
        while (i < count)
        begin
            if (count - i >= 4 && $urandom_range(0, 15) == 0)
            begin
                send_magic($urandom_range(0, 1) ? msfd_pkg::MAGIC_FRAME
                                                : msfd_pkg::MAGIC_STATE);
                i += 4;
            end
            else
            begin
                send_byte(8'($urandom));
                i++;
            end
        end
    endtask

    task automatic random_unit();
        int          sel;
        logic [7:0]  tail;
        logic [31:0] len;
        sel = $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0)
            clock_ms = $urandom;
        send_noise($urandom_range(0, 3));
        if (sel == 0)
        begin
            send_magic(msfd_pkg::MAGIC_STATE);
            send_byte(8'($urandom));
        end
        if (sel == 1)
        begin
            tail = 8'($urandom);
            if (tail == msfd_pkg::MAGIC_FRAME[7:0] || tail == msfd_pkg::MAGIC_STATE[7:0])
                tail = tail ^ 8'h80;
            send_byte(msfd_pkg::MAGIC_FRAME[31:24]);
            send_byte(msfd_pkg::MAGIC_FRAME[23:16]);
            send_byte(msfd_pkg::MAGIC_FRAME[15:8]);
            send_byte(tail);
        end
        else if (sel == 2)
            send_noise($urandom_range(4, 10));
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:    len = 32'd0;
                2:       len = $urandom_range(30, 80);
                default: len = $urandom_range(1, 12);
            endcase
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), len, len);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_setting(input logic [15:0] interval, input int unsigned step,
                               input int budget);
        int target;
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= interval;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
        ms_step_max = step;
        target = bytes_sent + budget;
        while (bytes_sent < target)
            random_unit();
    endtask

    initial
    begin
        logic [15:0] mid_interval;
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        idling = 1'b1;
        hold_off_request = 1'b0;
        clock_ms = 32'd0;
        ms_step_max = 0;
        bytes_sent = 0;
        settings_used = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // too soon after time zero: dropped, zero length
        send_frame(8'hFF, 8'h00, 8'hFF, 32'd0, 0);
        // forwarded zero-length frame carries last on its header
        clock_ms = 32'd1000;
        send_frame(8'h00, 8'hFF, 8'h00, 32'd0, 0);
        // same instant: dropped, its payload holds a sync word that must not be scanned
        send_frame(8'h5A, 8'hA5, 8'h80, 32'd4, 0);
        send_magic(msfd_pkg::MAGIC_FRAME);

        run_setting(msfd_pkg::MIN_INTERVAL_RESET, 60, 300);
        run_setting(16'd0, 20, 250);

        // hold the result side while a long forwarded frame keeps arriving
        hold_off_request = 1'b1;
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 32'd48, 48);
        drain_results();

        run_setting(16'hFFFF, 6000, 250);
        mid_interval = 16'($urandom_range(2, 65534));
        clock_ms = 32'hFFFF_F000;
        run_setting(mid_interval, 32'(mid_interval / 16'd8) + 1, 250);
        run_setting(16'd1, 1, 250);
        idling = 1'b0;
        run_setting(16'd200, 30, 250);

        // an all-ones length never completes, so it goes last
        run_setting(16'd0, 10, 0);
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 32'hFFFF_FFFF, 30);
        drain_results();

        $display("covered %0d bytes under %0d interval settings, with a long result hold-off",
                 bytes_sent, settings_used);
        $display("results seen: %0d forwarded headers, %0d dropped headers, %0d payload bytes",
                 forwarded_seen, dropped_seen, payload_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
